>>> rtl/core/bbct_pkg.sv
`default_nettype none

package bbct_pkg;

   // slots are searched in groups of this many, one priority encode per group
   localparam int GROUP_WIDTH = 32;
   localparam int LOCAL_BITS  = 5;

   localparam logic [7:0] REFS_MAX = 8'hFF;

   typedef enum logic [1:0] {
      OP_ACQUIRE    = 2'd0,
      OP_RELEASE    = 2'd1,
      OP_MARK_VALID = 2'd2
   } op_type;

   typedef enum logic [4:0] {
      ST_IDLE    = 5'b00001,
      ST_COMPARE = 5'b00010,
      ST_GROUP   = 5'b00100,
      ST_SELECT  = 5'b01000,
      ST_UPDATE  = 5'b10000
   } state_type;

   typedef struct packed {
      logic accept;
      logic compare;
      logic group;
      logic select;
      logic commit;
   } cmd_type;

endpackage

`default_nettype wire

>>> rtl/core/bbct_ctrl.sv
`default_nettype none

module bbct_ctrl (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output bbct_pkg::cmd_type      cmd
);

   bbct_pkg::state_type state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic out_free;
   logic commit;
   logic accept;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign commit    = (state_ff == bbct_pkg::ST_UPDATE) && out_free;
   assign req_stall = !((state_ff == bbct_pkg::ST_IDLE) || commit);
   assign accept    = req_valid && !req_stall;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      cmd.accept  = accept;
      cmd.compare = (state_ff == bbct_pkg::ST_COMPARE);
      cmd.group   = (state_ff == bbct_pkg::ST_GROUP);
      cmd.select  = (state_ff == bbct_pkg::ST_SELECT);
      cmd.commit  = commit;
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         bbct_pkg::ST_IDLE: begin
            if (accept) state_in = bbct_pkg::ST_COMPARE;
         end
         bbct_pkg::ST_COMPARE: state_in = bbct_pkg::ST_GROUP;
         bbct_pkg::ST_GROUP:   state_in = bbct_pkg::ST_SELECT;
         bbct_pkg::ST_SELECT:  state_in = bbct_pkg::ST_UPDATE;
         bbct_pkg::ST_UPDATE: begin
            // hold until the output register can take the transaction
            if (commit) state_in = accept ? bbct_pkg::ST_COMPARE : bbct_pkg::ST_IDLE;
         end
         default: state_in = bbct_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      if (commit) rsp_valid_in = 1'b1;
      else        rsp_valid_in = rsp_valid_ff && rsp_stall;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bbct_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

`default_nettype wire

>>> rtl/core/bbct_datapath.sv
`default_nettype none

module bbct_datapath #(
   parameter int SLOT_COUNT = 32
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire bbct_pkg::cmd_type  cmd,
   input  wire logic [1:0]         req_opcode,
   input  wire logic [7:0]         req_device_number,
   input  wire logic [31:0]        req_block_number,
   input  wire logic [4:0]         req_slot_index,
   output logic                    rsp_success,
   output logic [4:0]              rsp_granted_slot,
   output logic                    rsp_tag_hit,
   output logic                    rsp_needs_fill
);

   localparam int GW          = bbct_pkg::GROUP_WIDTH;
   localparam int LB          = bbct_pkg::LOCAL_BITS;
   localparam int SLOT_BITS   = (SLOT_COUNT > 2) ? $clog2(SLOT_COUNT) : 1;
   localparam int GROUP_COUNT = (SLOT_COUNT + GW - 1) / GW;
   localparam int GROUP_BITS  = (GROUP_COUNT > 1) ? $clog2(GROUP_COUNT) : 1;
   localparam int SLOT_WIDE   = GROUP_BITS + LB;
   localparam int PAD         = GROUP_COUNT * GW;

   // captured request
   bbct_pkg::op_type op_ff;
   logic [7:0]       dev_ff;
   logic [31:0]      blk_ff;
   logic [4:0]       slot_ff;

   // slot table
   logic [7:0]  tag_dev_ff [SLOT_COUNT];
   logic [31:0] tag_blk_ff [SLOT_COUNT];
   logic [SLOT_COUNT-1:0] written_ff;
   logic [7:0]  refs_ff    [SLOT_COUNT];
   logic [SLOT_COUNT-1:0] dvalid_ff;

   // search pipeline
   logic [PAD-1:0] match_ff, match_in;
   logic [PAD-1:0] free_ff, free_in;
   logic [GROUP_COUNT-1:0] ghit_any_ff, ghit_any_in;
   logic [GROUP_COUNT-1:0] gfree_any_ff, gfree_any_in;
   logic [LB-1:0] ghit_idx_ff  [GROUP_COUNT];
   logic [LB-1:0] ghit_idx_in  [GROUP_COUNT];
   logic [LB-1:0] gfree_idx_ff [GROUP_COUNT];
   logic [LB-1:0] gfree_idx_in [GROUP_COUNT];
   logic sel_hit_ff, sel_hit_in;
   logic sel_found_ff, sel_found_in;
   logic [SLOT_WIDE-1:0] sel_slot_ff, sel_slot_in;

   // update
   logic [SLOT_WIDE-1:0] req_wide;
   logic                 in_table;
   logic [SLOT_BITS-1:0] tgt;
   logic [7:0]           refs_rd;
   logic                 dvalid_rd;
   logic                 wr_refs, wr_tag, wr_dvalid, dvalid_new;
   logic [7:0]           refs_new;
   logic success_in, hit_in, fill_in;
   logic [4:0] granted_in;
   logic success_ff, hit_ff, fill_ff;
   logic [4:0] granted_ff;

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         op_ff   <= bbct_pkg::op_type'(req_opcode);
         dev_ff  <= req_device_number;
         blk_ff  <= req_block_number;
         slot_ff <= req_slot_index;
      end
   end

   // per-slot compare: an unwritten tag reads as device 0, block 0
   always_comb begin
      match_in = '0;
      free_in  = '0;
      for (int s = 0; s < SLOT_COUNT; s++) begin
         match_in[s] = ((written_ff[s] ? tag_dev_ff[s] : 8'd0) == dev_ff) &&
                       ((written_ff[s] ? tag_blk_ff[s] : 32'd0) == blk_ff);
         free_in[s]  = (refs_ff[s] == 8'd0);
      end
   end

   // per-group encode: highest match, lowest free
   always_comb begin
      for (int g = 0; g < GROUP_COUNT; g++) begin
         ghit_any_in[g]  = |match_ff[g*GW +: GW];
         gfree_any_in[g] = |free_ff[g*GW +: GW];
         ghit_idx_in[g]  = '0;
         gfree_idx_in[g] = '0;
         for (int b = 0; b < GW; b++) begin
            if (match_ff[g*GW + b]) ghit_idx_in[g] = LB'(b);
         end
         for (int b = GW - 1; b >= 0; b--) begin
            if (free_ff[g*GW + b]) gfree_idx_in[g] = LB'(b);
         end
      end
   end

   always_comb begin
      logic [SLOT_WIDE-1:0] hit_slot;
      logic [SLOT_WIDE-1:0] free_slot;
      hit_slot  = '0;
      free_slot = '0;
      for (int g = 0; g < GROUP_COUNT; g++) begin
         if (ghit_any_ff[g]) hit_slot = {GROUP_BITS'(g), ghit_idx_ff[g]};
      end
      for (int g = GROUP_COUNT - 1; g >= 0; g--) begin
         if (gfree_any_ff[g]) free_slot = {GROUP_BITS'(g), gfree_idx_ff[g]};
      end
      sel_hit_in   = |ghit_any_ff;
      sel_found_in = |gfree_any_ff;
      sel_slot_in  = sel_hit_in ? hit_slot : free_slot;
   end

   always_ff @(posedge clock) begin
      if (cmd.compare) begin
         match_ff <= match_in;
         free_ff  <= free_in;
      end
      if (cmd.group) begin
         ghit_any_ff  <= ghit_any_in;
         gfree_any_ff <= gfree_any_in;
         ghit_idx_ff  <= ghit_idx_in;
         gfree_idx_ff <= gfree_idx_in;
      end
      if (cmd.select) begin
         sel_hit_ff   <= sel_hit_in;
         sel_found_ff <= sel_found_in;
         sel_slot_ff  <= sel_slot_in;
      end
   end

   assign req_wide = SLOT_WIDE'(slot_ff);
   assign in_table = {1'b0, req_wide} < (SLOT_WIDE + 1)'(SLOT_COUNT);
   assign tgt      = (op_ff == bbct_pkg::OP_ACQUIRE) ? sel_slot_ff[SLOT_BITS-1:0]
                                                     : req_wide[SLOT_BITS-1:0];
   assign refs_rd   = refs_ff[tgt];
   assign dvalid_rd = dvalid_ff[tgt];

   always_comb begin
      wr_refs    = 1'b0;
      wr_tag     = 1'b0;
      wr_dvalid  = 1'b0;
      dvalid_new = 1'b0;
      refs_new   = refs_rd;
      success_in = 1'b0;
      granted_in = slot_ff;
      hit_in     = 1'b0;
      fill_in    = 1'b0;
      unique case (op_ff)
         bbct_pkg::OP_ACQUIRE: begin
            if (sel_hit_ff) begin
               granted_in = sel_slot_ff[4:0];
               hit_in     = 1'b1;
               // refuse when the count is saturated
               if (refs_rd != bbct_pkg::REFS_MAX) begin
                  wr_refs    = 1'b1;
                  refs_new   = refs_rd + 8'd1;
                  success_in = 1'b1;
                  fill_in    = !dvalid_rd;
               end
            end else if (sel_found_ff) begin
               granted_in = sel_slot_ff[4:0];
               wr_tag     = 1'b1;
               wr_refs    = 1'b1;
               refs_new   = 8'd1;
               wr_dvalid  = 1'b1;
               dvalid_new = 1'b0;
               success_in = 1'b1;
               fill_in    = 1'b1;
            end else begin
               granted_in = '0;
            end
         end
         bbct_pkg::OP_RELEASE: begin
            if (in_table && (refs_rd != 8'd0)) begin
               wr_refs    = 1'b1;
               refs_new   = refs_rd - 8'd1;
               success_in = 1'b1;
            end
         end
         bbct_pkg::OP_MARK_VALID: begin
            if (in_table) begin
               wr_dvalid  = 1'b1;
               dvalid_new = 1'b1;
               success_in = 1'b1;
            end
         end
         default: begin
            success_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         written_ff <= '0;
         dvalid_ff  <= '0;
         for (int s = 0; s < SLOT_COUNT; s++) refs_ff[s] <= 8'd0;
      end else if (cmd.commit) begin
         if (wr_refs)   refs_ff[tgt]    <= refs_new;
         if (wr_dvalid) dvalid_ff[tgt]  <= dvalid_new;
         if (wr_tag)    written_ff[tgt] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit && wr_tag) begin
         tag_dev_ff[tgt] <= dev_ff;
         tag_blk_ff[tgt] <= blk_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         success_ff <= success_in;
         granted_ff <= granted_in;
         hit_ff     <= hit_in;
         fill_ff    <= fill_in;
      end
   end

   assign rsp_success      = success_ff;
   assign rsp_granted_slot = granted_ff;
   assign rsp_tag_hit      = hit_ff;
   assign rsp_needs_fill   = fill_ff;

endmodule

`default_nettype wire

>>> rtl/core/block_buffer_cache_tags.sv
// Tag and reference-count table for a block buffer cache.
// Request channel (req_valid / req_stall): opcode acquire, release or
// mark-valid, with a device and block tag or a slot index. Response channel
// (rsp_valid / rsp_stall): one transaction per request carrying success, the
// slot, tag hit and whether a disk fill is needed.
// Steps: an accepted request passes through compare, group encode, select and
// update, each registered; the response is registered in the update step.
// A new request is taken at the edge where the previous one updates, so the
// block takes no new request until the previous one has reached its update.
// Requests are handled one at a time: the search sees the table as the
// previous request left it.
// When the receiver stalls, the response register holds; a request that has
// finished its search then waits in the update step and no further request
// is accepted until the response is taken.
// Reset clears all reference counts, data-valid marks and tags (every slot
// reads as device 0, block 0) and empties the response register; the block
// accepts requests from the first cycle after reset.
`default_nettype none

module block_buffer_cache_tags #(
   parameter int SLOT_COUNT = 32
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [1:0]  req_opcode,
   input  wire logic [7:0]  req_device_number,
   input  wire logic [31:0] req_block_number,
   input  wire logic [4:0]  req_slot_index,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic             rsp_success,
   output logic [4:0]       rsp_granted_slot,
   output logic             rsp_tag_hit,
   output logic             rsp_needs_fill
);

   bbct_pkg::cmd_type cmd;

   bbct_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd)
   );

   bbct_datapath #(
      .SLOT_COUNT (SLOT_COUNT)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .req_opcode        (req_opcode),
      .req_device_number (req_device_number),
      .req_block_number  (req_block_number),
      .req_slot_index    (req_slot_index),
      .rsp_success       (rsp_success),
      .rsp_granted_slot  (rsp_granted_slot),
      .rsp_tag_hit       (rsp_tag_hit),
      .rsp_needs_fill    (rsp_needs_fill)
   );

endmodule

`default_nettype wire

>>> tb/sv/tag_table_check.sv
`timescale 1ns / 1ps

module tag_table_check #(
   parameter int SLOTS = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [1:0]  req_opcode,
   input  logic [7:0]  req_device_number,
   input  logic [31:0] req_block_number,
   input  logic [4:0]  req_slot_index,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic        rsp_success,
   input  logic [4:0]  rsp_granted_slot,
   input  logic        rsp_tag_hit,
   input  logic        rsp_needs_fill,
   output int          mismatches,
   output int          outstanding
);

   typedef struct packed {
      logic       success;
      logic [4:0] slot;
      logic       hit;
      logic       fill;
   } grant_type;

   logic [7:0]  tag_dev   [SLOTS];
   logic [31:0] tag_blk   [SLOTS];
   logic [7:0]  ref_count [SLOTS];
   logic        filled    [SLOTS];

   grant_type grants_due[$];
   grant_type oldest;
   int        err_count = 0;
   int        due_count = 0;

   assign mismatches  = err_count;
   assign outstanding = due_count;

   // Work out the answer to one request and move the shadow table on.
   function automatic grant_type apply_request(input logic [1:0] op, input logic [7:0] dev,
                                               input logic [31:0] blk, input logic [4:0] idx);
      grant_type r;
      int        found;
      int        victim;
      found   = -1;
      victim  = -1;
      r.success = 1'b0;
      r.slot    = idx;
      r.hit     = 1'b0;
      r.fill    = 1'b0;
      case (op)
         bbct_pkg::OP_ACQUIRE: begin
            r.slot = '0;
            for (int s = SLOTS - 1; s >= 0; s--)
               if (found < 0 && tag_dev[s] == dev && tag_blk[s] == blk) found = s;
            if (found >= 0) begin
               r.slot = found[4:0];
               r.hit  = 1'b1;
               if (ref_count[found] != bbct_pkg::REFS_MAX) begin
                  ref_count[found] = ref_count[found] + 8'd1;
                  r.success = 1'b1;
                  r.fill    = !filled[found];
               end
            end else begin
               for (int s = 0; s < SLOTS; s++)
                  if (victim < 0 && ref_count[s] == 8'd0) victim = s;
               if (victim >= 0) begin
                  tag_dev[victim]   = dev;
                  tag_blk[victim]   = blk;
                  filled[victim]    = 1'b0;
                  ref_count[victim] = 8'd1;
                  r.success = 1'b1;
                  r.slot    = victim[4:0];
                  r.fill    = 1'b1;
               end
            end
         end
         bbct_pkg::OP_RELEASE: begin
            if (idx < SLOTS && ref_count[idx] != 8'd0) begin
               ref_count[idx] = ref_count[idx] - 8'd1;
               r.success = 1'b1;
            end
         end
         bbct_pkg::OP_MARK_VALID: begin
            if (idx < SLOTS) begin
               filled[idx] = 1'b1;
               r.success   = 1'b1;
            end
         end
         default: ;
      endcase
      return r;
   endfunction

   task automatic check_field(input string label, input int want, input int got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d actual %0d", $time, label, want, got);
         err_count++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < SLOTS; s++) begin
            tag_dev[s]   = '0;
            tag_blk[s]   = '0;
            ref_count[s] = '0;
            filled[s]    = 1'b0;
         end
         grants_due.delete();
      end else begin
         // push before pop: the front is always the older transaction
         if (req_valid && !req_stall)
            grants_due.push_back(apply_request(req_opcode, req_device_number,
                                               req_block_number, req_slot_index));
         if (rsp_valid && !rsp_stall) begin
            if (grants_due.size() == 0) begin
               $display("%0t: response transaction with nothing outstanding", $time);
               err_count++;
            end else begin
               oldest = grants_due.pop_front();
               check_field("success",      oldest.success, rsp_success);
               check_field("granted_slot", oldest.slot,    rsp_granted_slot);
               check_field("tag_hit",      oldest.hit,     rsp_tag_hit);
               check_field("needs_fill",   oldest.fill,    rsp_needs_fill);
            end
         end
      end
      due_count <= grants_due.size();
   end

endmodule

>>> tb/sv/tb.sv
`timescale 1ns / 1ps

module tb;

   localparam logic [1:0] OP_UNKNOWN  = 2'd3;
   localparam int         ITEM_TARGET = 1250;
   localparam int         CYCLE_LIMIT = 400_000;
   localparam int         TAG_POOL    = 12;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [1:0]  req_opcode = '0;
   logic [7:0]  req_device_number = '0;
   logic [31:0] req_block_number = '0;
   logic [4:0]  req_slot_index = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic        rsp_success;
   logic [4:0]  rsp_granted_slot;
   logic        rsp_tag_hit;
   logic        rsp_needs_fill;

   int mismatches;
   int outstanding;
   int cycles = 0;
   int issued = 0;
   int send_calm = 0;
   int recv_calm = 0;

   logic [7:0]  pool_dev [TAG_POOL];
   logic [31:0] pool_blk [TAG_POOL];

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   block_buffer_cache_tags DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_opcode       (req_opcode),
      .req_device_number(req_device_number),
      .req_block_number (req_block_number),
      .req_slot_index   (req_slot_index),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_success      (rsp_success),
      .rsp_granted_slot (rsp_granted_slot),
      .rsp_tag_hit      (rsp_tag_hit),
      .rsp_needs_fill   (rsp_needs_fill)
   );

   tag_table_check u_check (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_opcode       (req_opcode),
      .req_device_number(req_device_number),
      .req_block_number (req_block_number),
      .req_slot_index   (req_slot_index),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_success      (rsp_success),
      .rsp_granted_slot (rsp_granted_slot),
      .rsp_tag_hit      (rsp_tag_hit),
      .rsp_needs_fill   (rsp_needs_fill),
      .mismatches       (mismatches),
      .outstanding      (outstanding)
   );

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   // Offer one transaction after a random gap and hold it until taken.
   task automatic issue(input logic [1:0] op, input logic [7:0] dev,
                        input logic [31:0] blk, input logic [4:0] idx);
      int gap;
      if (send_calm > 0) begin
         send_calm--;
         gap = 0;
      end else begin
         gap = $urandom_range(0, 10);
         if ($urandom_range(0, 39) == 0) send_calm = $urandom_range(10, 40);
      end
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_opcode        <= op;
      req_device_number <= dev;
      req_block_number  <= blk;
      req_slot_index    <= idx;
      do @(posedge clock); while (!(req_valid && !req_stall));
      issued++;
   endtask

   // Low slots are where allocation lands, so aim most releases there.
   function automatic logic [4:0] likely_slot();
      if ($urandom_range(0, 3) == 0) return 5'($urandom_range(0, 31));
      return 5'($urandom_range(0, 15));
   endfunction

   task automatic random_item();
      int pick;
      int k;
      pick = $urandom_range(0, 99);
      k    = $urandom_range(0, TAG_POOL - 1);
      if (pick < 30)
         issue(bbct_pkg::OP_ACQUIRE, pool_dev[k], pool_blk[k], 5'($urandom));
      else if (pick < 36)
         issue(bbct_pkg::OP_ACQUIRE, 8'($urandom), $urandom, 5'($urandom));
      else if (pick < 80)
         issue(bbct_pkg::OP_RELEASE, 8'($urandom), $urandom, likely_slot());
      else if (pick < 95)
         issue(bbct_pkg::OP_MARK_VALID, 8'($urandom), $urandom,
               5'($urandom_range(0, 31)));
      else
         issue(OP_UNKNOWN, 8'($urandom), $urandom, 5'($urandom));
   endtask

   // Exhaust the table with fresh tags, then drain it with a release sweep.
   task automatic fill_and_drain();
      repeat (34) issue(bbct_pkg::OP_ACQUIRE, 8'($urandom), $urandom, 5'($urandom));
      for (int s = 0; s < 32; s++)
         issue(bbct_pkg::OP_RELEASE, 8'($urandom), $urandom, s[4:0]);
   endtask

   initial begin : stimulus
      logic [7:0]  sat_dev;
      logic [31:0] sat_blk;
      bit          saturated;
      saturated = 1'b0;
      pool_dev[0] = 8'h00;
      pool_blk[0] = 32'h0000_0000;
      pool_dev[1] = 8'hFF;
      pool_blk[1] = 32'hFFFF_FFFF;
      for (int k = 2; k < TAG_POOL; k++) begin
         pool_dev[k] = 8'($urandom_range(0, 3));
         pool_blk[k] = $urandom;
      end

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // after reset every slot holds tag (0, 0): expect the top slot to hit
      issue(bbct_pkg::OP_ACQUIRE, 8'h00, 32'h0000_0000, 5'd0);
      issue(bbct_pkg::OP_ACQUIRE, 8'hFF, 32'hFFFF_FFFF, 5'd31);
      issue(bbct_pkg::OP_ACQUIRE, 8'hFF, 32'hFFFF_FFFF, 5'd0);
      issue(bbct_pkg::OP_MARK_VALID, 8'hFF, 32'hFFFF_FFFF, 5'd0);
      issue(bbct_pkg::OP_ACQUIRE, 8'hFF, 32'hFFFF_FFFF, 5'd0);
      repeat (4) issue(bbct_pkg::OP_RELEASE, 8'h00, 32'h0000_0000, 5'd0);
      // tag and valid mark survive the release
      issue(bbct_pkg::OP_ACQUIRE, 8'hFF, 32'hFFFF_FFFF, 5'd0);
      issue(bbct_pkg::OP_RELEASE, 8'h00, 32'h0000_0000, 5'd31);
      issue(bbct_pkg::OP_RELEASE, 8'h00, 32'h0000_0000, 5'd31);
      issue(bbct_pkg::OP_RELEASE, 8'hFF, 32'hFFFF_FFFF, 5'd5);
      issue(bbct_pkg::OP_MARK_VALID, 8'h00, 32'h0000_0000, 5'd31);
      issue(OP_UNKNOWN, 8'hFF, 32'hFFFF_FFFF, 5'd31);
      issue(OP_UNKNOWN, 8'h00, 32'h0000_0000, 5'd0);
      issue(bbct_pkg::OP_ACQUIRE, 8'h55, 32'hAAAA_AAAA, 5'd10);
      issue(bbct_pkg::OP_ACQUIRE, 8'hAA, 32'h5555_5555, 5'd21);
      issue(bbct_pkg::OP_ACQUIRE, 8'h00, 32'h0000_0000, 5'd0);
      issue(bbct_pkg::OP_RELEASE, 8'h00, 32'h0000_0000, 5'd0);

      while (issued < ITEM_TARGET) begin
         if (!saturated && issued > 300) begin
            // drive one count to its ceiling so the last acquires are refused
            sat_dev = 8'($urandom);
            sat_blk = $urandom;
            repeat (257) issue(bbct_pkg::OP_ACQUIRE, sat_dev, sat_blk, 5'($urandom));
            saturated = 1'b1;
         end else if ($urandom_range(0, 149) == 0)
            fill_and_drain();
         else
            random_item();
      end
      req_valid <= 1'b0;

      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (mismatches == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

   initial begin : receiver
      int hold;
      int taken;
      taken = 0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (taken == 300 || taken == 800) begin
            // long hold-off: let the block back up into its request side
            hold = 250;
         end else if (recv_calm > 0) begin
            recv_calm--;
            hold = 0;
         end else begin
            hold = $urandom_range(0, 10);
            if ($urandom_range(0, 39) == 0) recv_calm = $urandom_range(10, 40);
         end
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!(rsp_valid && !rsp_stall));
         taken++;
      end
   end

endmodule
